@@ rtl/tfs_pkg.sv @@
package tfs_pkg;

    localparam int STORE_DEPTH = 18;
    localparam int POS_W       = 5;

    localparam logic [7:0] HDR_BYTE  = 8'hAA;
    localparam logic [7:0] ID_STATUS = 8'h01;
    localparam logic [7:0] ID_MOTOR  = 8'h06;
    localparam logic [7:0] ID_SENSOR = 8'h02;

    localparam logic [POS_W-1:0] LEN_STATUS = 5'd12;
    localparam logic [POS_W-1:0] LEN_MOTOR  = 5'd16;
    localparam logic [POS_W-1:0] LEN_SENSOR = 5'd18;

    // header bytes ahead of the payload: two sync bytes, id, length
    localparam logic [POS_W-1:0] HDR_LEN = 5'd4;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_MOTOR  = 2'd1,
        KIND_SENSOR = 2'd2,
        KIND_NONE   = 2'd3
    } req_kind_t;

    // one frame ready to transmit
    typedef struct packed {
        logic [7:0]                       id;
        logic [POS_W-1:0]                 len;
        logic [STORE_DEPTH-1:0][7:0]      payload;
    } frame_desc_t;

    // queue head as seen by the transmitter
    typedef struct packed {
        logic        valid;
        frame_desc_t desc;
    } queue_head_t;

endpackage

@@ rtl/tfs_front.sv @@
module tfs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic [9*32-1:0]      values,
    output logic                 push,
    input  logic                 push_ready,
    output tfs_pkg::frame_desc_t push_desc
);

    logic                 front_valid_reg;
    logic                 front_valid_next;
    tfs_pkg::frame_desc_t desc_reg;
    tfs_pkg::frame_desc_t desc_next;
    logic                 load;

    // Q8 degrees to hundredths, truncated toward zero, low 16 bits.
    // Only product bits [23:0] matter; sign of the product is the sign of v.
    function automatic logic [15:0] angle_hundredths(input logic [31:0] v);
        logic [23:0] p;
        p = (v[23:0] << 6) + (v[23:0] << 5) + (v[23:0] << 2);
        return p[23:8] + {15'd0, v[31] & (p[7:0] != 8'd0)};
    endfunction

    function automatic logic [15:0] word_of(input logic [9*32-1:0] vals, input int k);
        return vals[k*32 +: 16];
    endfunction

    assign in_ready = !front_valid_reg || push_ready;
    assign push     = front_valid_reg;
    assign push_desc = desc_reg;
    assign load     = in_valid && in_ready && (req_type != tfs_pkg::KIND_NONE);

    always_comb
    begin
        desc_next = '0;
        case (req_type)
            tfs_pkg::KIND_STATUS:
            begin
                desc_next.id  = tfs_pkg::ID_STATUS;
                desc_next.len = tfs_pkg::LEN_STATUS;
                {desc_next.payload[0], desc_next.payload[1]} = angle_hundredths(values[31:0]);
                {desc_next.payload[2], desc_next.payload[3]} = angle_hundredths(values[63:32]);
                {desc_next.payload[4], desc_next.payload[5]} = angle_hundredths(values[95:64]);
                desc_next.payload[6]  = values[127:120];
                desc_next.payload[7]  = values[119:112];
                desc_next.payload[8]  = values[111:104];
                desc_next.payload[9]  = values[103:96];
                desc_next.payload[10] = values[135:128];
                desc_next.payload[11] = values[167:160];
            end
            tfs_pkg::KIND_MOTOR, tfs_pkg::KIND_SENSOR:
            begin
                desc_next.id  = (req_type == tfs_pkg::KIND_MOTOR) ? tfs_pkg::ID_MOTOR
                                                                  : tfs_pkg::ID_SENSOR;
                desc_next.len = (req_type == tfs_pkg::KIND_MOTOR) ? tfs_pkg::LEN_MOTOR
                                                                  : tfs_pkg::LEN_SENSOR;
                for (int k = 0; k < 9; k++)
                begin
                    {desc_next.payload[2*k], desc_next.payload[2*k+1]} = word_of(values, k);
                end
            end
            default:
            begin
                desc_next = '0;
            end
        endcase
    end

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (load)
            front_valid_next = 1'b1;
        else if (push_ready)
            front_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            desc_reg <= desc_next;
    end

endmodule

@@ rtl/tfs_queue.sv @@
module tfs_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 push_ready,
    input  tfs_pkg::frame_desc_t push_desc,
    output tfs_pkg::queue_head_t head,
    input  logic                 pop
);

    tfs_pkg::frame_desc_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;

    assign push_ready = (count_reg != 2'd2);
    assign do_push    = push && push_ready;
    assign head.valid = (count_reg != 2'd0);
    assign head.desc  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

endmodule

@@ rtl/tfs_back.sv @@
module tfs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tfs_pkg::queue_head_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 out_last
);

    logic [tfs_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                sum_reg, sum_next;
    logic                      valid_reg, valid_next;
    logic [7:0]                byte_reg;
    logic                      last_reg;
    logic                      advance;
    logic                      is_last;
    logic [tfs_pkg::POS_W-1:0] idx;
    logic [7:0]                cur_byte;

    assign advance = head.valid && (!valid_reg || out_ready);
    assign is_last = (pos_reg == head.desc.len + tfs_pkg::HDR_LEN);
    assign idx     = pos_reg - tfs_pkg::HDR_LEN;
    assign pop     = advance && is_last;

    always_comb
    begin
        if (is_last)
            cur_byte = sum_reg;
        else if (pos_reg < 5'd2)
            cur_byte = tfs_pkg::HDR_BYTE;
        else if (pos_reg == 5'd2)
            cur_byte = head.desc.id;
        else if (pos_reg == 5'd3)
            cur_byte = {3'd0, head.desc.len};
        else if (idx < 5'(tfs_pkg::STORE_DEPTH))
            cur_byte = head.desc.payload[idx];
        else
            cur_byte = 8'd0;
    end

    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        valid_next = valid_reg && !out_ready;
        if (advance)
        begin
            valid_next = 1'b1;
            if (is_last)
            begin
                pos_next = '0;
                sum_next = 8'd0;
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
                sum_next = sum_reg + cur_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= 8'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= cur_byte;
            last_reg <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> pos_reg <= head.desc.len + tfs_pkg::HDR_LEN)
        else $error("byte position past end of frame");

    a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !head.valid |-> (pos_reg == '0 && sum_reg == 8'd0))
        else $error("sequencer not parked between frames");

    a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> sum_reg == 8'd0 && pos_reg == '0)
        else $error("checksum not cleared after frame end");

endmodule

@@ rtl/telemetry_frame_serializer.sv @@
// Channel  Dir  Signals                          Item
// s_axis   in   tvalid tready tdata tuser        one telemetry request
// m_axis   out  tvalid tready tdata tlast        one frame byte
//
// A request of kind status, motor or sensor yields 17, 21 or 23 bytes, one per cycle unless m_axis stalls.
// The byte sequencer emits one byte per cycle while m_axis_tready is high.
// The front stage and a two-entry frame queue take new requests while a frame is out,
// so up to three requests can be held before s_axis_tready drops.
// Request kind 3 is accepted and dropped without output.
// rst_n is asynchronous, active low; it empties the queue and parks the sequencer.
// A stall on m_axis holds the output byte; the front keeps filling the queue.
module telemetry_frame_serializer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // value0 [31:0], value1 [63:32], ... value8 [287:256]
    input  logic [287:0]    s_axis_tdata,
    // req_type [1:0]
    input  logic [1:0]      s_axis_tuser,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // frame_byte [7:0]
    output logic [7:0]      m_axis_tdata,
    output logic            m_axis_tlast
);

    logic                 push;
    logic                 push_ready;
    tfs_pkg::frame_desc_t push_desc;
    tfs_pkg::queue_head_t head;
    logic                 pop;

    // front: classify request, convert angles, pack payload bytes
    tfs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .req_type   (s_axis_tuser),
        .values     (s_axis_tdata),
        .push       (push),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    // frames waiting for the transmitter
    tfs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .head       (head),
        .pop        (pop)
    );

    // back: byte sequencer with running checksum and output register
    tfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
